>>> rtl/apa_pkg.sv
// Shared types and constants for the audio playout admission block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package apa_pkg;

  // Result kinds carried on the kind output.
  localparam logic [1:0] KIND_QUEUED  = 2'd0;
  localparam logic [1:0] KIND_DROPPED = 2'd1;
  localparam logic [1:0] KIND_TRIMMED = 2'd2;
  localparam logic [1:0] KIND_FREED   = 2'd3;

  // Input commands.
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_DONE   = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_QUEUED  = 2'd0;
  localparam logic [1:0] REG_PREBUFFER   = 2'd1;
  localparam logic [1:0] REG_MAX_CONCEAL = 2'd2;

  // Reset values.
  localparam logic [4:0]  RST_MAX_QUEUED   = 5'd12;
  localparam logic [4:0]  RST_PREBUFFER    = 5'd3;
  localparam logic [2:0]  RST_MAX_CONCEAL  = 3'd3;
  localparam logic [9:0]  RST_FRAME_SAMPLES = 10'd480;

  // Sequence gaps above this distance count as late packets.
  localparam logic [15:0] LATE_LIMIT = 16'h8000;
  localparam logic [15:0] COUNT_SAT  = 16'hFFFF;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // capture the input beat
    logic emit;   // produce one result and update state
  } apa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic final_beat;  // the next result is the last one for this item
  } apa_sts_t;

endpackage

`default_nettype wire

>>> rtl/apa_ctrl.sv
// Sequencer for the playout admission block: accepts an item, then steps
// through its results one by one. Depends on apa_pkg.
`default_nettype none

module apa_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  apa_pkg::apa_sts_t sts_i,
  output apa_pkg::apa_cmd_t cmd_o
);
  import apa_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.final_beat) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/apa_dp.sv
// Datapath of the playout admission block: configuration registers, ring
// state, the captured item and the output register. Depends on apa_pkg.
`default_nettype none

module apa_dp #(
  parameter int RING_SLOTS = 24,
  parameter int MAX_FRAME  = 960
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  apa_pkg::apa_cmd_t cmd_i,
  output apa_pkg::apa_sts_t sts_o,
  input  wire               cfg_valid_i,
  input  wire [1:0]         cfg_index_i,
  input  wire [4:0]         cfg_data_i,
  input  wire               cmd_in_i,
  input  wire [15:0]        sequence_req_i,
  input  wire [9:0]         frame_samples_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [1:0]        kind_o,
  output logic [4:0]        slot_o,
  output logic [9:0]        samples_o,
  output logic              is_concealment_o,
  output logic              paused_o,
  output logic [4:0]        queued_now_o,
  output logic [15:0]       concealed_total_o,
  output logic              last_o
);
  import apa_pkg::*;

  localparam int SlotW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CntW  = $clog2(RING_SLOTS + 1);
  localparam int CmpW  = (CntW > 5) ? CntW : 5;
  localparam int FrmW  = 12;

  // Configuration.
  logic [4:0] max_queued_q;
  logic [4:0] prebuffer_q;
  logic [2:0] max_conceal_q;

  // Admission state.
  logic             have_seq_q, have_seq_d;
  logic [15:0]      prev_seq_q, prev_seq_d;
  logic [CntW-1:0]  in_flight_q, in_flight_d;
  logic [SlotW-1:0] next_slot_q, next_slot_d;
  logic             prebuf_q, prebuf_d;
  logic [9:0]       prev_fs_q, prev_fs_d;
  logic [15:0]      conceal_cnt_q, conceal_cnt_d;

  // Captured item.
  logic        item_cmd_q;
  logic        item_drop_q;
  logic [2:0]  item_cnt_q, item_cnt_d;
  logic [15:0] item_seq_q;
  logic [9:0]  item_fs_q;

  // Output register.
  logic        out_valid_q;
  logic [1:0]  res_kind;
  logic [4:0]  res_slot;
  logic [9:0]  res_samples;
  logic        res_conc;
  logic        res_last;

  // Decisions made while capturing the item.
  logic [15:0] gap_m1;
  logic        ld_drop;
  logic [2:0]  ld_cnt;
  logic [9:0]  ld_fs;

  always_comb begin
    gap_m1  = sequence_req_i - prev_seq_q - 16'd1;
    ld_drop = have_seq_q &&
              ((sequence_req_i == prev_seq_q) || (gap_m1 >= LATE_LIMIT));
    if (!have_seq_q) begin
      ld_cnt = 3'd0;
    end else if (gap_m1 > {13'd0, max_conceal_q}) begin
      ld_cnt = max_conceal_q;
    end else begin
      ld_cnt = gap_m1[2:0];
    end
    if (FrmW'(frame_samples_i) > FrmW'(MAX_FRAME)) begin
      ld_fs = 10'(MAX_FRAME);
    end else begin
      ld_fs = frame_samples_i;
    end
  end

  // One result per emit step.
  logic            frame_conc;
  logic            is_frame;
  logic [9:0]      adm_samples;
  logic            adm_pb;
  logic            adm_trim;
  logic [CntW-1:0] adm_inc;

  always_comb begin
    frame_conc  = !item_cmd_q && !item_drop_q && (item_cnt_q != 3'd0);
    is_frame    = !item_cmd_q && !item_drop_q;
    adm_samples = frame_conc ? prev_fs_q : item_fs_q;
    adm_pb      = prebuf_q || (in_flight_q == '0);
    adm_trim    = (adm_samples == 10'd0) ||
                  (CmpW'(in_flight_q) >= CmpW'(max_queued_q)) ||
                  (in_flight_q >= CntW'(RING_SLOTS));
    adm_inc     = in_flight_q + CntW'(1);

    sts_o.out_free   = !out_valid_q || !out_stall_i;
    sts_o.final_beat = !frame_conc;

    have_seq_d    = have_seq_q;
    prev_seq_d    = prev_seq_q;
    in_flight_d   = in_flight_q;
    next_slot_d   = next_slot_q;
    prebuf_d      = prebuf_q;
    prev_fs_d     = prev_fs_q;
    conceal_cnt_d = conceal_cnt_q;
    item_cnt_d    = item_cnt_q;
    res_kind      = KIND_DROPPED;
    res_slot      = 5'd0;
    res_samples   = 10'd0;
    res_conc      = 1'b0;
    res_last      = !frame_conc;

    if (item_cmd_q == CMD_DONE) begin
      res_kind = KIND_FREED;
      if (in_flight_q != '0) begin
        in_flight_d = in_flight_q - CntW'(1);
      end
    end else if (is_frame) begin
      res_samples = adm_samples;
      res_conc    = frame_conc;
      prebuf_d    = adm_pb;
      if (frame_conc) begin
        item_cnt_d = item_cnt_q - 3'd1;
      end else begin
        have_seq_d = 1'b1;
        prev_seq_d = item_seq_q;
      end
      if (adm_trim) begin
        res_kind = KIND_TRIMMED;
      end else begin
        res_kind    = KIND_QUEUED;
        res_slot    = 5'(next_slot_q);
        in_flight_d = adm_inc;
        if (next_slot_q == SlotW'(RING_SLOTS - 1)) begin
          next_slot_d = '0;
        end else begin
          next_slot_d = next_slot_q + SlotW'(1);
        end
        if (adm_pb && (CmpW'(adm_inc) >= CmpW'(prebuffer_q))) begin
          prebuf_d = 1'b0;
        end
        if (frame_conc) begin
          if (conceal_cnt_q != COUNT_SAT) begin
            conceal_cnt_d = conceal_cnt_q + 16'd1;
          end
        end else begin
          prev_fs_d = adm_samples;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_queued_q  <= RST_MAX_QUEUED;
      prebuffer_q   <= RST_PREBUFFER;
      max_conceal_q <= RST_MAX_CONCEAL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_QUEUED:  max_queued_q  <= cfg_data_i;
        REG_PREBUFFER:   prebuffer_q   <= cfg_data_i;
        REG_MAX_CONCEAL: max_conceal_q <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_seq_q    <= 1'b0;
      prev_seq_q    <= 16'd0;
      in_flight_q   <= '0;
      next_slot_q   <= '0;
      prebuf_q      <= 1'b1;
      prev_fs_q     <= RST_FRAME_SAMPLES;
      conceal_cnt_q <= 16'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        have_seq_q    <= have_seq_d;
        prev_seq_q    <= prev_seq_d;
        in_flight_q   <= in_flight_d;
        next_slot_q   <= next_slot_d;
        prebuf_q      <= prebuf_d;
        prev_fs_q     <= prev_fs_d;
        conceal_cnt_q <= conceal_cnt_d;
      end
      out_valid_q <= cmd_i.emit || (out_valid_q && out_stall_i);
    end
  end

  // Item capture and result payload need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_cmd_q  <= cmd_in_i;
      item_drop_q <= ld_drop;
      item_cnt_q  <= ld_cnt;
      item_seq_q  <= sequence_req_i;
      item_fs_q   <= ld_fs;
    end else if (cmd_i.emit) begin
      item_cnt_q <= item_cnt_d;
    end
    if (cmd_i.emit) begin
      kind_o            <= res_kind;
      slot_o            <= res_slot;
      samples_o         <= res_samples;
      is_concealment_o  <= res_conc;
      paused_o          <= prebuf_d;
      queued_now_o      <= 5'(in_flight_d);
      concealed_total_o <= conceal_cnt_d;
      last_o            <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/audio_playout_admission.sv
// Top level of the audio playout admission block.
// Instantiates apa_ctrl and apa_dp; types and constants come from apa_pkg.
`default_nettype none

// Audio playout admission decides which audio frames enter a playout ring
// of RING_SLOTS buffers. A packet beat (cmd 0) carries a sequence number and
// a frame length; a buffer-done beat (cmd 1) frees one queued frame and
// yields one kind 3 result. A packet whose sequence gap is zero or beyond
// half the sequence space is dropped with one kind 1 result. Otherwise up to
// max_conceal concealment frames, each as long as the last queued packet
// frame, come first, then the packet's own frame; every frame is either
// queued into the next ring slot (kind 0) or trimmed (kind 2) when the queue
// is at max_queued, the ring is full or the frame has zero samples. Playback
// is flagged paused on underrun and resumes once prebuffer_frames frames are
// queued. Each item gives one to eight results and the last one carries
// last_o. The sequencer takes an item, then emits one result per cycle into
// the output register while the output side does not stall. The next item
// can be accepted while the final result still waits in the output register.
// Configuration writes are always ready and must be issued only while the
// block is idle.

module audio_playout_admission #(
  parameter int RING_SLOTS = 24,
  parameter int MAX_FRAME  = 960
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration write port.
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [4:0]  cfg_data_i,
  // Input beats.
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         cmd_i,
  input  wire  [15:0] sequence_req_i,
  input  wire  [9:0]  frame_samples_i,
  // Result beats.
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  kind_o,
  output logic [4:0]  slot_o,
  output logic [9:0]  samples_o,
  output logic        is_concealment_o,
  output logic        paused_o,
  output logic [4:0]  queued_now_o,
  output logic [15:0] concealed_total_o,
  output logic        last_o
);
  import apa_pkg::*;

  apa_cmd_t ctl_cmd;
  apa_sts_t dp_sts;

  // Registers are plain flops, so the port never waits.
  assign cfg_ready_o = 1'b1;

  apa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctl_cmd)
  );

  apa_dp #(
    .RING_SLOTS (RING_SLOTS),
    .MAX_FRAME  (MAX_FRAME)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (ctl_cmd),
    .sts_o             (dp_sts),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_in_i          (cmd_i),
    .sequence_req_i    (sequence_req_i),
    .frame_samples_i   (frame_samples_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .slot_o            (slot_o),
    .samples_o         (samples_o),
    .is_concealment_o  (is_concealment_o),
    .paused_o          (paused_o),
    .queued_now_o      (queued_now_o),
    .concealed_total_o (concealed_total_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

>>> rtl/apa_checker.sv
// Port-level checks for the audio playout admission block, bound to the
// top level. Depends on apa_pkg for the result kind codes.
`default_nettype none

module apa_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  kind_o,
  input wire [4:0]  slot_o,
  input wire [9:0]  samples_o,
  input wire        is_concealment_o,
  input wire        last_o
);
  import apa_pkg::*;

  // A result beat held back by the consumer stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat withdrawn while stalled");

  // After an input beat is taken the block is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second input beat taken before results were produced");

  // Drops and frees are single, payload-free results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DROPPED || kind_o == KIND_FREED) |->
      last_o && slot_o == 5'd0 && samples_o == 10'd0 && !is_concealment_o)
    else $error("drop or free result with frame payload");

  // A concealment frame is never the final result of its packet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_concealment_o |-> !last_o)
    else $error("concealment frame marked last");

  // Trimmed frames get no ring slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TRIMMED |-> slot_o == 5'd0)
    else $error("trimmed frame carries a slot");

endmodule

bind audio_playout_admission apa_checker u_apa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .slot_o           (slot_o),
  .samples_o        (samples_o),
  .is_concealment_o (is_concealment_o),
  .last_o           (last_o)
);

`default_nettype wire
